>>> src/iravg_pkg.sv
// Shared types, constants and the range classifier for the IR distance averager.
package iravg_pkg;

    // Widest converter supported; classifier works at this width.
    localparam int ADC_MAX_BITS = 12;
    localparam int ADC_BITS_DEF = 10;

    localparam int SUM_W  = 12;
    localparam int CNT_W  = 8;
    localparam int CFG_W  = 8;
    localparam int DIST_W = 4;
    localparam int REM_W  = CFG_W;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = CFG_W'(10);
    localparam logic [CFG_W-1:0] REJECT_LIMIT_RST = CFG_W'(30);

    // Register indexes on the config port.
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_REJECT_LIMIT = 1'b1;

    // Range ladder bounds (exclusive on both sides).
    localparam logic [ADC_MAX_BITS-1:0] R2_LO  = ADC_MAX_BITS'(473);
    localparam logic [ADC_MAX_BITS-1:0] R2_HI  = ADC_MAX_BITS'(530);
    localparam logic [ADC_MAX_BITS-1:0] R3_LO  = ADC_MAX_BITS'(335);
    localparam logic [ADC_MAX_BITS-1:0] R3_HI  = ADC_MAX_BITS'(366);
    localparam logic [ADC_MAX_BITS-1:0] R4_LO  = ADC_MAX_BITS'(246);
    localparam logic [ADC_MAX_BITS-1:0] R4_HI  = ADC_MAX_BITS'(268);
    localparam logic [ADC_MAX_BITS-1:0] R5_LO  = ADC_MAX_BITS'(195);
    localparam logic [ADC_MAX_BITS-1:0] R5_HI  = ADC_MAX_BITS'(229);
    localparam logic [ADC_MAX_BITS-1:0] R6_LO  = ADC_MAX_BITS'(175);
    localparam logic [ADC_MAX_BITS-1:0] R6_HI  = ADC_MAX_BITS'(191);
    localparam logic [ADC_MAX_BITS-1:0] R7_LO  = ADC_MAX_BITS'(143);
    localparam logic [ADC_MAX_BITS-1:0] R7_HI  = ADC_MAX_BITS'(167);
    localparam logic [ADC_MAX_BITS-1:0] R8_LO  = ADC_MAX_BITS'(121);
    localparam logic [ADC_MAX_BITS-1:0] R8_HI  = ADC_MAX_BITS'(136);
    localparam logic [ADC_MAX_BITS-1:0] R9_LO  = ADC_MAX_BITS'(107);
    localparam logic [ADC_MAX_BITS-1:0] R9_HI  = ADC_MAX_BITS'(135);
    localparam logic [ADC_MAX_BITS-1:0] R10_HI = ADC_MAX_BITS'(100);

    localparam logic [DIST_W-1:0] DIST_REJECT = '0;
    localparam logic [DIST_W-1:0] AVG_MAX     = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic finish;
        logic div_last;
        logic out_free;
    } t_status;

    // First matching range wins; 0 means rejected.
    function automatic logic [DIST_W-1:0] classify(input logic [ADC_MAX_BITS-1:0] v);
        logic [DIST_W-1:0] d;
        if (v > R2_LO && v < R2_HI)      d = DIST_W'(2);
        else if (v > R3_LO && v < R3_HI) d = DIST_W'(3);
        else if (v > R4_LO && v < R4_HI) d = DIST_W'(4);
        else if (v > R5_LO && v < R5_HI) d = DIST_W'(5);
        else if (v > R6_LO && v < R6_HI) d = DIST_W'(6);
        else if (v > R7_LO && v < R7_HI) d = DIST_W'(7);
        else if (v > R8_LO && v < R8_HI) d = DIST_W'(8);
        else if (v > R9_LO && v < R9_HI) d = DIST_W'(9);
        else if (v < R10_HI)             d = DIST_W'(10);
        else                             d = DIST_REJECT;
        return d;
    endfunction

endpackage

>>> src/iravg_ctrl.sv
// Controller FSM: accept requests, run the divider, hand off the result.
module iravg_ctrl
    import iravg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.finish) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> src/iravg_dp.sv
// Datapath: config registers, classifier, accumulators, divider, output register.
module iravg_dp
    import iravg_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [ADC_BITS-1:0] i_sample,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [DIST_W-1:0]   o_average_inches,
    output logic                o_ended_by_rejects,
    input  t_cmd                i_cmd,
    output t_status             o_status
);

    logic [CFG_W-1:0]  r_sample_count, r_reject_limit;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_rej, n_rej;

    logic [SUM_W-1:0]  r_quo;      // dividend in, quotient out
    logic [REM_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_early;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_avg;
    logic              r_out_early;

    logic [DIST_W-1:0] reading_dist;
    logic [CFG_W-1:0]  target;
    logic              early_hit;
    logic              finish;
    logic [REM_W:0]    shifted, diff;
    logic              q_bit;

    // Config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
            r_reject_limit <= REJECT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                REG_REJECT_LIMIT: r_reject_limit <= i_cfg_data;
                default:          r_sample_count <= r_sample_count;
            endcase
        end
    end

    // Classify and update the running counts
    always_comb begin
        reading_dist = classify(ADC_MAX_BITS'(i_sample));
        target       = (r_sample_count == '0) ? CFG_W'(1) : r_sample_count;
        early_hit    = 1'b0;
        n_sum        = r_sum;
        n_pos        = r_pos;
        n_rej        = r_rej;
        if (reading_dist != DIST_REJECT) begin
            n_sum = r_sum + SUM_W'(reading_dist);
            n_pos = r_pos + CNT_W'(1);
        end else if (r_rej == r_reject_limit) begin
            early_hit = 1'b1;
        end else begin
            if (r_pos == '0) n_pos = CNT_W'(1);
            n_rej = r_rej + CNT_W'(1);
        end
        finish = early_hit || (n_pos >= target);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_pos <= '0;
            r_rej <= '0;
        end else if (i_cmd.accept) begin
            if (finish) begin
                r_sum <= '0;
                r_pos <= '0;
                r_rej <= '0;
            end else begin
                r_sum <= n_sum;
                r_pos <= n_pos;
                r_rej <= n_rej;
            end
        end
    end

    // Restoring divider, one quotient bit per step
    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        diff    = shifted - {1'b0, r_div};
        q_bit   = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && finish) begin
            r_quo   <= n_sum;
            r_rem   <= '0;
            r_div   <= target;
            r_early <= early_hit;
            r_step  <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_W-2:0], q_bit};
            r_rem  <= q_bit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg       <= (|r_quo[SUM_W-1:DIST_W]) ? AVG_MAX : r_quo[DIST_W-1:0];
            r_out_early <= r_early;
        end
    end

    assign o_status.finish   = finish;
    assign o_status.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_average_inches   = r_avg;
    assign o_ended_by_rejects = r_out_early;

endmodule

>>> src/ir_distance_sample_averager.sv
// Top level of the IR distance sample averager: controller plus datapath.
//
// Input channel: i_in_valid / o_in_ready carry one raw sensor reading
// (i_sample) per request. Output channel: o_out_valid / i_out_ready carry
// one averaged distance (o_average_inches, o_ended_by_rejects) per finished
// measurement. Config: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 = sample_count, 1 = reject_limit) in the same cycle.
//
// Timing: a reading that does not finish a measurement leaves the block idle
// and ready. A finishing reading starts the shared restoring divider at one
// quotient bit per cycle over the sum width, then loads the output register
// once it is free; the next request is taken the cycle after the load.
// o_in_ready is low only while the divider runs or waits to load.
//
// Reset (synchronous, active low) clears sum, counts, FSM and output valid,
// and loads sample_count = 10, reject_limit = 30.
// Receiver stall: a held result sits in the output register while new
// readings are still accepted; a second result waits in the divider until
// the output register is taken.
module ir_distance_sample_averager
    import iravg_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ADC_BITS-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DIST_W-1:0]   o_average_inches,
    output logic                o_ended_by_rejects
);

    t_cmd    cmd;
    t_status status;

    iravg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    iravg_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_sample           (i_sample),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_average_inches   (o_average_inches),
        .o_ended_by_rejects (o_ended_by_rejects),
        .i_cmd              (cmd),
        .o_status           (status)
    );

endmodule

>>> sim/ir_distance_average_checker.sv
// Checker for the IR distance sample averager: predicts each average and compares it.
module ir_distance_average_checker
    import iravg_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [ADC_BITS-1:0] i_sample,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [DIST_W-1:0]   i_average_inches,
    input  logic                i_ended_by_rejects,
    output int                  o_pending,
    output int                  o_fail_count,
    output int                  o_average_count,
    output int                  o_early_count
);

    typedef struct packed {
        logic [DIST_W-1:0] inches;
        logic              early;
    } t_average;

    t_average         expected_averages[$];

    logic [CFG_W-1:0] samples_per_avg;
    logic [CFG_W-1:0] reject_limit;
    logic [SUM_W-1:0] inch_sum;
    logic [CNT_W-1:0] positions;
    logic [CNT_W-1:0] rejects;

    int fails;
    int averages;
    int early_ends;

    // Ladder is tried top down; the 8 in band shadows the upper part of the 9 in band.
    function automatic logic [DIST_W-1:0] inches_of(input logic [ADC_BITS-1:0] v);
        if (v >= 474 && v <= 529) return DIST_W'(2);
        if (v >= 336 && v <= 365) return DIST_W'(3);
        if (v >= 247 && v <= 267) return DIST_W'(4);
        if (v >= 196 && v <= 228) return DIST_W'(5);
        if (v >= 176 && v <= 190) return DIST_W'(6);
        if (v >= 144 && v <= 166) return DIST_W'(7);
        if (v >= 122 && v <= 135) return DIST_W'(8);
        if (v >= 108 && v <= 134) return DIST_W'(9);
        if (v <= 99)              return DIST_W'(10);
        return DIST_REJECT;
    endfunction

    task automatic absorb_reading(input logic [ADC_BITS-1:0] v);
        logic [DIST_W-1:0] d;
        logic [CNT_W-1:0]  target;
        logic [SUM_W-1:0]  quotient;
        logic              done;
        logic              early;
        d = inches_of(v);
        target = (samples_per_avg == '0) ? CNT_W'(1) : CNT_W'(samples_per_avg);
        done = 1'b0;
        early = 1'b0;
        if (d != DIST_REJECT) begin
            inch_sum = inch_sum + SUM_W'(d);
            positions = positions + 1'b1;
        end else if (rejects == reject_limit) begin
            done = 1'b1;
            early = 1'b1;
        end else begin
            // a reject as the very first position counts as zero inches
            if (positions == '0) positions = CNT_W'(1);
            rejects = rejects + 1'b1;
        end
        if (positions >= target) done = 1'b1;
        if (done) begin
            quotient = inch_sum / SUM_W'(target);
            expected_averages.push_back('{(quotient > SUM_W'(AVG_MAX)) ? AVG_MAX
                                                                     : quotient[DIST_W-1:0],
                                          early});
            inch_sum = '0;
            positions = '0;
            rejects = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        fails++;
        $display("%0t: average mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_average got;
        t_average want;
        if (!i_rst_n) begin
            samples_per_avg = SAMPLE_COUNT_RST;
            reject_limit = REJECT_LIMIT_RST;
            inch_sum = '0;
            positions = '0;
            rejects = '0;
            expected_averages.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SAMPLE_COUNT: samples_per_avg = i_cfg_data;
                    REG_REJECT_LIMIT: reject_limit = i_cfg_data;
                    default: ;
                endcase
            end
            // A result leaving at this edge comes from an earlier request: retire it first.
            if (i_out_valid && i_out_ready) begin
                got = '{i_average_inches, i_ended_by_rejects};
                averages++;
                if (expected_averages.size() == 0) begin
                    report_mismatch($sformatf("unexpected average %0d early %0b",
                                              got.inches, got.early));
                end else begin
                    want = expected_averages.pop_front();
                    if (want.early) early_ends++;
                    if (got.inches !== want.inches)
                        report_mismatch($sformatf("average %0d, expected %0d",
                                                  got.inches, want.inches));
                    if (got.early !== want.early)
                        report_mismatch($sformatf("ended_by_rejects %0b, expected %0b",
                                                  got.early, want.early));
                end
            end
            if (i_in_valid && i_in_ready) absorb_reading(i_sample);
        end
        o_pending <= expected_averages.size();
        o_fail_count <= fails;
        o_average_count <= averages;
        o_early_count <= early_ends;
    end

endmodule

>>> sim/ir_distance_sample_averager_test.sv
// Testbench top for the IR distance sample averager: stimulus, idling and verdict.
module ir_distance_sample_averager_test;
    import iravg_pkg::*;

    localparam int ADC_BITS = ADC_BITS_DEF;

    // Covers the divider plus output load, with margin: the block is surely quiet after this.
    localparam int DRAIN_CYCLES = 24;
    // Cycles allowed for the last averages to come out once stimulus has stopped.
    localparam int END_WAIT_LIMIT = 20000;
    // Time limit for the whole run, well above the slowest correct run.
    localparam int RUN_LIMIT = 1600000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // All block inputs start at known values.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = REG_SAMPLE_COUNT;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic [ADC_BITS-1:0] i_sample = '0;
    logic                i_out_ready = 1'b0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [DIST_W-1:0]   o_average_inches;
    logic                o_ended_by_rejects;

    // From the checker, all updated at the clock edge.
    int pending;
    int fail_count;
    int averages_seen;
    int early_ends;

    // Chance, in percent, that the sender idles / the receiver stalls in a cycle.
    int idle_pct = 0;
    int stall_pct = 0;

    int readings_sent = 0;
    int settings_run = 0;

    // Both edges of every ladder band, in ladder order: with one position per
    // average each reading comes straight back as its own distance.
    int ladder_edges[$] = '{474, 529, 336, 365, 247, 267, 196, 228, 176, 190,
                            144, 166, 122, 135, 108, 121, 0, 99};

    // Random phases: register setting, reject share and idling style per phase.
    // The 255 setting is run once only, as it takes 255 positions per average.
    int phase_samples[$] = '{10, 1, 3, 2, 5, 255, 4, 0, 7, 10, 2, 1};
    int phase_limit[$]   = '{30, 0, 1, 255, 3, 30, 2, 5, 0, 255, 1, 4};
    int phase_rejects[$] = '{20, 15, 50, 30, 60, 3, 40, 25, 15, 70, 35, 45};
    int phase_items[$]   = '{100, 100, 100, 100, 100, 300, 100, 100, 100, 100, 100, 100};

    ir_distance_sample_averager #(
        .ADC_BITS(ADC_BITS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_average_inches  (o_average_inches),
        .o_ended_by_rejects(o_ended_by_rejects)
    );

    ir_distance_average_checker #(
        .ADC_BITS(ADC_BITS)
    ) average_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_average_inches  (o_average_inches),
        .i_ended_by_rejects(o_ended_by_rejects),
        .o_pending         (pending),
        .o_fail_count      (fail_count),
        .o_average_count   (averages_seen),
        .o_early_count     (early_ends)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: ready is redrawn every cycle, independent of valid.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the handshake hangs somewhere.
    initial begin
        #RUN_LIMIT;
        $display("run time limit reached, %0d averages still due", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                idle_pct = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_pct = 73;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                idle_pct = 0;
                stall_pct = 73;
            end
            default: begin
                idle_pct = 7;
                stall_pct = 7;
            end
        endcase
    endtask

    // One request on the input channel. Valid is only lowered for a gap, and
    // every lowering is followed by a clock edge before valid rises again.
    // o_in_ready is read right after the edge, so it is the value that edge saw.
    task automatic send_reading(input logic [ADC_BITS-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (!o_in_ready);
        readings_sent++;
    endtask

    // Hold the sender off until every predicted average has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Registers only change with nothing due; a partly built measurement may
    // still be held, which is how the average can overflow and saturate.
    task automatic configure(input int samples, input int limit);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_SAMPLE_COUNT;
        i_cfg_data <= CFG_W'(samples);
        @(posedge i_clk);
        i_cfg_index <= REG_REJECT_LIMIT;
        i_cfg_data <= CFG_W'(limit);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_run++;
    endtask

    // Band readings, or at reject_pct percent rejects drawn from the gaps between
    // bands, above the ladder or the full range; now and then pinned to a range edge.
    function automatic logic [ADC_BITS-1:0] pick_reading(input int reject_pct);
        int lo;
        int hi;
        if ($urandom_range(99) < reject_pct) begin
            case ($urandom_range(8))
                0: begin lo = 100; hi = 107; end
                1: begin lo = 136; hi = 143; end
                2: begin lo = 167; hi = 175; end
                3: begin lo = 191; hi = 195; end
                4: begin lo = 229; hi = 246; end
                5: begin lo = 268; hi = 335; end
                6: begin lo = 366; hi = 473; end
                7: begin lo = 530; hi = 1023; end
                default: begin lo = 0; hi = 1023; end
            endcase
        end else begin
            case ($urandom_range(8))
                0: begin lo = 474; hi = 529; end
                1: begin lo = 336; hi = 365; end
                2: begin lo = 247; hi = 267; end
                3: begin lo = 196; hi = 228; end
                4: begin lo = 176; hi = 190; end
                5: begin lo = 144; hi = 166; end
                6: begin lo = 122; hi = 135; end
                7: begin lo = 108; hi = 121; end
                default: begin lo = 0; hi = 99; end
            endcase
        end
        case ($urandom_range(9))
            0: return ADC_BITS'(lo);
            1: return ADC_BITS'(hi);
            default: return ADC_BITS'($urandom_range(hi, lo));
        endcase
    endfunction

    initial begin
        int waited;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part ----
        set_idling(IDLE_NONE);

        // One position per average, and the smallest reject limit: every band
        // edge returns its distance, and a reject at count zero ends at once.
        configure(1, 0);
        foreach (ladder_edges[k]) send_reading(ADC_BITS'(ladder_edges[k]));
        send_reading(ADC_BITS'(1023));
        send_reading(ADC_BITS'(100));

        // Largest settings: a leading reject becomes a zero-inch position, then
        // three 10 in readings and a reject that leaves the position count alone.
        configure(255, 255);
        send_reading(ADC_BITS'(1023));
        send_reading(ADC_BITS'(99));
        send_reading(ADC_BITS'(0));
        send_reading(ADC_BITS'(50));
        send_reading(ADC_BITS'(400));
        // Zero positions act as one; the 40 in sum then saturates the average.
        configure(0, 255);
        send_reading(ADC_BITS'(99));

        // ---- Random part ----
        foreach (phase_samples[p]) begin
            configure(phase_samples[p], phase_limit[p]);
            set_idling(t_idle_mode'(p % 4));
            repeat (phase_items[p]) begin
                // occasional hold-off until all due averages are out
                if ($urandom_range(199) == 0) drain();
                send_reading(pick_reading(phase_rejects[p]));
            end
        end

        // ---- Wind down ----
        i_in_valid <= 1'b0;
        stall_pct = 0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < END_WAIT_LIMIT);

        if (pending != 0) begin
            $display("timed out with %0d averages still due", pending);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            // catch any stray average after the last expected one
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            $display("covered %0d readings over %0d register settings, %0d averages checked",
                     readings_sent, settings_run, averages_seen);
            $display("%0d averages cut short by rejects; idling ran none, sender, receiver, both",
                     early_ends);
            if (fail_count == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("%0d mismatches", fail_count);
                $display("[FAIL] regression broken");
            end
            $finish;
        end
    end

endmodule
